@@ hdl/cpsr_pkg.sv @@
// shared constants and types for the column power sum reduction unit
package cpsr_pkg;

  // parameter defaults
  localparam int MAX_COLUMNS_DEF     = 1024;
  localparam int MAX_POWER_LEVEL_DEF = 3;
  localparam int PAD_MULTIPLE_DEF    = 16;

  // field and register widths
  localparam int DATA_W     = 32;
  localparam int SUM_W      = 48;
  localparam int AXIS_W     = 12;
  localparam int AXIS_CFG_W = 13;
  localparam int AXIS_LIMIT = 4096;
  localparam int SLICE_W    = 11;
  localparam int POWER_W    = 2;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int SQ_W       = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POWER_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_ZERO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_ONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_TWO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_LEN   = 3'd4;

  // register reset values
  localparam logic [POWER_W-1:0]    POWER_RESET = 2'd1;
  localparam logic [AXIS_CFG_W-1:0] AXIS_RESET  = 13'd1;
  localparam logic [SLICE_W-1:0]    SLICE_RESET = 11'd16;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // last index along each reduced axis
  typedef struct packed {
    logic [AXIS_W-1:0] zero_last;
    logic [AXIS_W-1:0] one_last;
    logic [AXIS_W-1:0] two_last;
  } axis_last_t;

  // classification of one request
  typedef struct packed {
    logic first_row;
    logic final_row;
    logic last_col;
  } flags_t;

endpackage

@@ hdl/cpsr_front.sv @@
// front end: accepts elements, tracks column and row position, tags each request
module cpsr_front import cpsr_pkg::*; #(
  parameter int COL_W = $clog2(MAX_COLUMNS_DEF)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] element_value,
  input  logic [COL_W-1:0]  pad_last,
  input  axis_last_t        axis_last,
  input  logic              q_full,
  output logic              push,
  output logic [DATA_W-1:0] push_value,
  output logic [COL_W-1:0]  push_col,
  output flags_t            push_flags
);

  logic [COL_W-1:0]  column_counter;
  logic [AXIS_W-1:0] row_counter_a;
  logic [AXIS_W-1:0] row_counter_b;
  logic [AXIS_W-1:0] row_counter_c;
  logic [COL_W-1:0]  col;
  logic              end_row;
  logic              end_a;
  logic              end_b;
  logic              end_c;

  // handshake straight onto the queue
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // position decode; counters past a shrunk limit end at once
  assign end_row = (column_counter >= pad_last);
  assign col     = end_row ? pad_last : column_counter;
  assign end_a   = (row_counter_a >= axis_last.two_last);
  assign end_b   = (row_counter_b >= axis_last.one_last);
  assign end_c   = (row_counter_c >= axis_last.zero_last);

  assign push_value           = element_value;
  assign push_col             = col;
  assign push_flags.first_row = (row_counter_a == '0) && (row_counter_b == '0) &&
                                (row_counter_c == '0);
  assign push_flags.final_row = end_a && end_b && end_c;
  assign push_flags.last_col  = end_row;

  // column and row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter_a  <= '0;
      row_counter_b  <= '0;
      row_counter_c  <= '0;
    end else if (push) begin
      if (!end_row) begin
        column_counter <= col + COL_W'(1);
      end else begin
        column_counter <= '0;
        if (!end_a) begin
          row_counter_a <= row_counter_a + AXIS_W'(1);
        end else begin
          row_counter_a <= '0;
          if (!end_b) begin
            row_counter_b <= row_counter_b + AXIS_W'(1);
          end else begin
            row_counter_b <= '0;
            if (!end_c) begin
              row_counter_c <= row_counter_c + AXIS_W'(1);
            end else begin
              row_counter_c <= '0;
            end
          end
        end
      end
    end
  end

endmodule

@@ hdl/cpsr_queue.sv @@
// small request queue that decouples the front end from the back end
module cpsr_queue import cpsr_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ hdl/cpsr_back.sv @@
// back end: repeated squaring, column accumulator memory and result register
module cpsr_back import cpsr_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int COL_W       = $clog2(MAX_COLUMNS_DEF)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  logic [DATA_W-1:0] head_value,
  input  logic [COL_W-1:0]  head_col,
  input  flags_t            head_flags,
  output logic              pop,
  input  logic [SQ_W-1:0]   sq_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [COL_W-1:0]  column_index,
  output logic [SUM_W-1:0]  column_total,
  output logic              last_column
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SQ   = 4'b0010,
    S_READ = 4'b0100,
    S_ACC  = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [SQ_W-1:0]   sq_left;
  logic [DATA_W-1:0] val;
  logic [COL_W-1:0]  col;
  flags_t            flags;
  logic [SUM_W-1:0]  rd_sum;
  logic [SUM_W-1:0]  column_sums [MAX_COLUMNS];

  logic [DATA_W-1:0]   mag;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]   sq_sat;
  logic [SUM_W:0]      add;
  logic [SUM_W-1:0]    val_ext;
  logic [SUM_W-1:0]    sum;
  logic                advance;
  logic                acc_fire;

  // saturating square of the magnitude, shared by every squaring step
  assign mag    = val[DATA_W-1] ? (DATA_W'(0) - val) : val;
  assign prod   = mag * mag;
  assign sq_sat = (|prod[2*DATA_W-1:DATA_W+15]) ? {1'b0, {(DATA_W-1){1'b1}}}
                                                : prod[DATA_W+15:16];

  // saturating accumulate; first row overwrites
  assign val_ext = {{(SUM_W-DATA_W){val[DATA_W-1]}}, val};
  assign add     = {rd_sum[SUM_W-1], rd_sum} + {val_ext[SUM_W-1], val_ext};
  always_comb begin
    if (flags.first_row) begin
      sum = val_ext;
    end else if (add[SUM_W] != add[SUM_W-1]) begin
      sum = add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum = add[SUM_W-1:0];
    end
  end

  // a final row result may retire once the output register is free or draining; other rows always retire
  assign advance  = !flags.final_row || !out_valid || !out_stall;
  assign acc_fire = (state == S_ACC) && advance;
  assign pop      = (state == S_IDLE) && head_valid;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (head_valid) state_next = (sq_count != '0) ? S_SQ : S_READ;
      S_SQ:   if (sq_left == SQ_W'(1)) state_next = S_READ;
      S_READ: state_next = S_ACC;
      S_ACC:  if (advance) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers of the current request
  always_ff @(posedge clk) begin
    if (pop) begin
      val     <= head_value;
      col     <= head_col;
      flags   <= head_flags;
      sq_left <= sq_count;
    end else if (state == S_SQ) begin
      val     <= sq_sat;
      sq_left <= sq_left - SQ_W'(1);
    end
  end

  // accumulator memory, registered read
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_sum <= column_sums[col];
    end
    if (acc_fire) begin
      column_sums[col] <= sum;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc_fire && flags.final_row) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_fire && flags.final_row) begin
      column_index <= col;
      column_total <= sum;
      last_column  <= flags.last_col;
    end
  end

`ifndef SYNTHESIS
  a_sq_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ) |-> (sq_left != '0))
    else $error("squaring step entered with no squarings left");
  a_final_out: assert property (@(posedge clk) disable iff (rst)
    (acc_fire && flags.final_row) |=> out_valid)
    else $error("final row total not presented");
  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_SQ || state == S_READ))
    else $error("request popped without starting work");
`endif

endmodule

@@ hdl/column_power_sum_reduction_unit.sv @@
// top level: configuration registers, front end, request queue and back end
// per element: s = power_level - 1 squarings, then column sum read and accumulate
// the back end sequencer takes a new element only once done with the last; it
//   shares one squaring multiplier and the single port of the column sum memory
// queue takes up to four elements ahead of the back end, one per cycle unless full
// reset: counters clear, registers take reset values, column sums are not cleared
module column_power_sum_reduction_unit import cpsr_pkg::*; #(
  parameter int MAX_COLUMNS     = MAX_COLUMNS_DEF,
  parameter int MAX_POWER_LEVEL = MAX_POWER_LEVEL_DEF,
  parameter int PAD_MULTIPLE    = PAD_MULTIPLE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [DATA_W-1:0]       element_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [$clog2(MAX_COLUMNS)-1:0] column_index,
  output logic signed [SUM_W-1:0]        column_total,
  output logic                           last_column
);

  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int LEN_W   = $clog2(MAX_COLUMNS + PAD_MULTIPLE);
  localparam int RSH     = LEN_W + $clog2(PAD_MULTIPLE);
  localparam int RECIP_W = RSH + 1;
  localparam int RECIP   = ((1 << RSH) + PAD_MULTIPLE - 1) / PAD_MULTIPLE;
  localparam int ENTRY_W = DATA_W + COL_W + $bits(flags_t);

  // last padded column for a slice length: round up by reciprocal multiply
  function automatic logic [COL_W-1:0] pad_last_of(input logic [SLICE_W-1:0] s);
    logic [LEN_W-1:0]         len;
    logic [LEN_W-1:0]         n;
    logic [LEN_W+RECIP_W-1:0] prod;
    logic [LEN_W-1:0]         q;
    logic [LEN_W-1:0]         pad;
    if (s == '0) begin
      len = LEN_W'(1);
    end else if (int'(s) > MAX_COLUMNS) begin
      len = LEN_W'(MAX_COLUMNS);
    end else begin
      len = LEN_W'(s);
    end
    n    = len + LEN_W'(PAD_MULTIPLE - 1);
    prod = (LEN_W + RECIP_W)'(n) * (LEN_W + RECIP_W)'(RECIP);
    q    = LEN_W'(prod >> RSH);
    pad  = q * LEN_W'(PAD_MULTIPLE);
    if (int'(pad) > MAX_COLUMNS) begin
      pad = LEN_W'(MAX_COLUMNS);
    end
    return COL_W'(pad - LEN_W'(1));
  endfunction

  // last index of an axis, size clamped into one to the axis limit
  function automatic logic [AXIS_W-1:0] axis_last_of(input logic [AXIS_CFG_W-1:0] v);
    logic [AXIS_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > AXIS_LIMIT) begin
      r = AXIS_W'(AXIS_LIMIT - 1);
    end else begin
      r = AXIS_W'(v - AXIS_CFG_W'(1));
    end
    return r;
  endfunction

  logic [POWER_W-1:0]    power_level;
  logic [AXIS_CFG_W-1:0] axis_zero_size;
  logic [AXIS_CFG_W-1:0] axis_one_size;
  logic [AXIS_CFG_W-1:0] axis_two_size;
  logic [COL_W-1:0]      pad_last;
  axis_last_t            axis_last;
  logic [POWER_W:0]      level;
  logic [SQ_W-1:0]       sq_count;

  logic               q_full;
  logic               push;
  logic [DATA_W-1:0]  push_value;
  logic [COL_W-1:0]   push_col;
  flags_t             push_flags;
  logic               pop;
  logic               head_valid;
  logic [ENTRY_W-1:0] head_data;
  logic [DATA_W-1:0]  head_value;
  logic [COL_W-1:0]   head_col;
  flags_t             head_flags;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      power_level    <= POWER_RESET;
      axis_zero_size <= AXIS_RESET;
      axis_one_size  <= AXIS_RESET;
      axis_two_size  <= AXIS_RESET;
      pad_last       <= pad_last_of(SLICE_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POWER_LEVEL: power_level    <= cfg_data[POWER_W-1:0];
        REG_AXIS_ZERO:   axis_zero_size <= cfg_data[AXIS_CFG_W-1:0];
        REG_AXIS_ONE:    axis_one_size  <= cfg_data[AXIS_CFG_W-1:0];
        REG_AXIS_TWO:    axis_two_size  <= cfg_data[AXIS_CFG_W-1:0];
        REG_SLICE_LEN:   pad_last       <= pad_last_of(cfg_data[SLICE_W-1:0]);
        default: ;
      endcase
    end
  end

  // clamped limits
  assign axis_last.zero_last = axis_last_of(axis_zero_size);
  assign axis_last.one_last  = axis_last_of(axis_one_size);
  assign axis_last.two_last  = axis_last_of(axis_two_size);

  always_comb begin
    if (power_level == '0) begin
      level = (POWER_W + 1)'(1);
    end else if (int'(power_level) > MAX_POWER_LEVEL) begin
      level = (POWER_W + 1)'(MAX_POWER_LEVEL);
    end else begin
      level = {1'b0, power_level};
    end
  end
  assign sq_count = SQ_W'(level - (POWER_W + 1)'(1));

  cpsr_front #(
    .COL_W(COL_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .element_value(element_value),
    .pad_last     (pad_last),
    .axis_last    (axis_last),
    .q_full       (q_full),
    .push         (push),
    .push_value   (push_value),
    .push_col     (push_col),
    .push_flags   (push_flags)
  );

  cpsr_queue #(
    .W    (ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_value, push_col, push_flags}),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_data (head_data)
  );

  assign head_value = head_data[ENTRY_W-1 -: DATA_W];
  assign head_col   = head_data[$bits(flags_t) +: COL_W];
  assign head_flags = head_data[$bits(flags_t)-1:0];

  cpsr_back #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .COL_W      (COL_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_value  (head_value),
    .head_col    (head_col),
    .head_flags  (head_flags),
    .pop         (pop),
    .sq_count    (sq_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .column_index(column_index),
    .column_total(column_total),
    .last_column (last_column)
  );

endmodule
